// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block average pooling project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define BAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define BAP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/core/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared constants and types of the block average pooling core.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int IMAGE_SIDE_DEF = 28;
    localparam int BLOCK_SIZE_DEF = 4;

    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = 255;
    localparam int BIN_W      = 6;
    localparam int LEVEL_W    = 7;
    localparam int OUT_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

    // block number and end-of-image mark traveling with a result
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             last;
    } t_tag;

    typedef struct packed {
        t_tag               tag;
        logic [LEVEL_W-1:0] level;
    } t_result;

endpackage

// File: rtl/core/block_average_pooling_top.sv
// ----------------------------------------------------------------------------
// block_average_pooling_top
// Mean brightness of each BLOCK_SIZE x BLOCK_SIZE block of a raster image.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; tready drops only on a block's last pixel
//   while eight results are already pending (output queue plus pipeline).
// Pipeline: a result reaches the output queue through the sum read-modify-write
//   stage, then the three-stage level unit.
// Reset: synchronous; clears counters, pipeline valids and the output queue.
//   The sum memory is not swept: during the first pixel row after reset the
//   first read of each block column is taken as zero, so no clearing pass.
module block_average_pooling_top import bap_pkg::*; #(
    parameter int IMAGE_SIDE = IMAGE_SIDE_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave side
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [PIX_W-1:0]      i_s_axis_tdata,   // [7:0] pixel
    // master side
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [5:0] bin_index, [12:6] level_hundredths
    output logic                  o_m_axis_tlast    // last_bin
);

    localparam int BPR       = IMAGE_SIDE / BLOCK_SIZE;
    localparam int MEM_DEPTH = (BPR > 0) ? BPR : 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int BLK_W     = ($clog2(BPR + 1) > 0) ? $clog2(BPR + 1) : 1;
    localparam int CNT_W     = $clog2(IMAGE_SIDE);
    localparam int SUB_W     = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int FULL_SUM  = PIX_MAX * BLOCK_SIZE * BLOCK_SIZE;
    localparam int SUM_W     = $clog2(FULL_SUM + 1);

    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = FPTR_W + 1;
    localparam int OCC_W      = FCNT_W + 1;

    localparam logic [CNT_W-1:0] COL_LAST = CNT_W'(IMAGE_SIDE - 1);
    localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(BLOCK_SIZE - 1);
    localparam logic [BLK_W-1:0] BLK_LIM  = BLK_W'(BPR);
    localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BPR - 1);

    // ---------------- raster position ----------------
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [SUB_W-1:0] r_sub_col, r_sub_row, n_sub_col, n_sub_row;
    logic [BLK_W-1:0] r_blk_col, r_blk_row, n_blk_col, n_blk_row;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic             r_first_row;     // fill mark: memory holds no data yet

    logic in_acc, in_span, emit_now, last_now;

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign in_span  = (r_blk_col < BLK_LIM) && (r_blk_row < BLK_LIM);
    assign emit_now = in_span && (r_sub_col == SUB_LAST) && (r_sub_row == SUB_LAST);
    assign last_now = (r_blk_col == BLK_LAST) && (r_blk_row == BLK_LAST);

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_sub_col = r_sub_col;
        n_sub_row = r_sub_row;
        n_blk_col = r_blk_col;
        n_blk_row = r_blk_row;
        n_bin     = r_bin;
        if (r_col == COL_LAST) begin
            n_col     = '0;
            n_sub_col = '0;
            n_blk_col = '0;
            if (r_row == COL_LAST) begin
                n_row     = '0;
                n_sub_row = '0;
                n_blk_row = '0;
            end else begin
                n_row = r_row + 1'b1;
                if (r_sub_row == SUB_LAST) begin
                    n_sub_row = '0;
                    if (r_blk_row != BLK_LIM) n_blk_row = r_blk_row + 1'b1;
                end else begin
                    n_sub_row = r_sub_row + 1'b1;
                end
            end
        end else begin
            n_col = r_col + 1'b1;
            if (r_sub_col == SUB_LAST) begin
                n_sub_col = '0;
                if (r_blk_col != BLK_LIM) n_blk_col = r_blk_col + 1'b1;
            end else begin
                n_sub_col = r_sub_col + 1'b1;
            end
        end
        // block numbers run in emit order; restart after the image's last block
        if (emit_now) n_bin = last_now ? '0 : r_bin + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_sub_col   <= '0;
            r_sub_row   <= '0;
            r_blk_col   <= '0;
            r_blk_row   <= '0;
            r_bin       <= '0;
            r_first_row <= 1'b1;
        end else if (in_acc) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_sub_col <= n_sub_col;
            r_sub_row <= n_sub_row;
            r_blk_col <= n_blk_col;
            r_blk_row <= n_blk_row;
            r_bin     <= n_bin;
            if (r_col == COL_LAST) r_first_row <= 1'b0;
        end
    end

    // ---------------- band sum memory, read-modify-write ----------------
    logic [SUM_W-1:0]  r_mem [MEM_DEPTH];
    logic [SUM_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] rd_addr;

    logic              r_s1_v;        // stage 1 holds an in-span pixel
    logic              r_s1_emit;
    logic              r_s1_zero;     // base reads as zero (never written)
    logic              r_s1_fwd;      // base comes from the write at the read edge
    logic [SUM_W-1:0]  r_s1_fwd_data;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [PIX_W-1:0]  r_s1_pix;
    t_tag              r_s1_tag;

    logic [SUM_W-1:0]  s1_base, s1_sum, wr_data;

    assign rd_addr = ADDR_W'(r_blk_col);

    always_comb begin
        if (r_s1_fwd)       s1_base = r_s1_fwd_data;
        else if (r_s1_zero) s1_base = '0;
        else                s1_base = r_rd_data;
        s1_sum  = s1_base + SUM_W'(r_s1_pix);
        wr_data = r_s1_emit ? '0 : s1_sum;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && in_span) r_rd_data <= r_mem[rd_addr];
        if (r_s1_v)            r_mem[r_s1_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= in_acc && in_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_emit     <= emit_now;
            r_s1_zero     <= r_first_row && (r_sub_col == '0);
            r_s1_fwd      <= r_s1_v && (r_s1_addr == rd_addr);
            r_s1_fwd_data <= wr_data;
            r_s1_addr     <= rd_addr;
            r_s1_pix      <= i_s_axis_tdata;
            r_s1_tag.bin  <= r_bin;
            r_s1_tag.last <= last_now;
        end
    end

    // ---------------- level unit ----------------
    logic               lvl_valid;
    logic [LEVEL_W-1:0] lvl_level;
    t_tag               lvl_tag;
    logic [1:0]         lvl_pending;

    bap_level #(
        .BLOCK_SIZE (BLOCK_SIZE)
    ) u_level (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_v && r_s1_emit),
        .i_sum     (s1_sum),
        .i_tag     (r_s1_tag),
        .o_valid   (lvl_valid),
        .o_level   (lvl_level),
        .o_tag     (lvl_tag),
        .o_pending (lvl_pending)
    );

    // ---------------- output queue ----------------
    t_result           r_q [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wptr, r_rptr;
    logic [FCNT_W-1:0] r_fcnt;
    logic              pop;
    logic [OCC_W-1:0]  occ;
    t_result           head;

    assign pop  = o_m_axis_tvalid && i_m_axis_tready;
    assign head = r_q[r_rptr];

    // every result not yet delivered holds a queue slot in advance
    assign occ = OCC_W'(r_fcnt) + OCC_W'(r_s1_v && r_s1_emit) + OCC_W'(lvl_pending);
    assign o_s_axis_tready = !emit_now || (occ < OCC_W'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (lvl_valid) r_q[r_wptr] <= '{tag: lvl_tag, level: lvl_level};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
        end else begin
            if (lvl_valid) r_wptr <= r_wptr + 1'b1;
            if (pop)       r_rptr <= r_rptr + 1'b1;
            r_fcnt <= r_fcnt + FCNT_W'(lvl_valid) - FCNT_W'(pop);
        end
    end

    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign o_m_axis_tdata  = OUT_DATA_W'({head.level, head.tag.bin});
    assign o_m_axis_tlast  = head.tag.last;

endmodule

// File: rtl/core/bap_level.sv
// ----------------------------------------------------------------------------
// bap_level
// Block sum to mean level in hundredths, rounded half up, three stages.
// ----------------------------------------------------------------------------
module bap_level import bap_pkg::*; #(
    parameter  int BLOCK_SIZE = BLOCK_SIZE_DEF,
    localparam int FULL_SUM   = PIX_MAX * BLOCK_SIZE * BLOCK_SIZE,
    localparam int SUM_W      = $clog2(FULL_SUM + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [SUM_W-1:0]   i_sum,
    input  t_tag               i_tag,
    output logic               o_valid,
    output logic [LEVEL_W-1:0] o_level,
    output t_tag               o_tag,
    output logic [1:0]         o_pending
);

    // level = floor((200*S + D) / (2*D)), D = full-scale sum
    localparam int SCALE  = 200;
    localparam int NUM_W  = $clog2(201 * FULL_SUM + 1);
    localparam int DIV    = 2 * FULL_SUM;
    localparam int L_W    = $clog2(DIV);
    localparam int SHIFT  = NUM_W + L_W;
    localparam int M_W    = NUM_W + 1;
    localparam int PROD_W = NUM_W + M_W;
    localparam int Q_W    = PROD_W - SHIFT;

    // ceil(2^SHIFT / DIV): exact floor for every numerator below 2^NUM_W
    localparam longint unsigned RECIP_L =
        ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [M_W-1:0]   RECIP = RECIP_L[M_W-1:0];
    localparam logic [NUM_W-1:0] BIAS  = NUM_W'(FULL_SUM);

    logic               r_v2, r_v3, r_v4;
    logic [SUM_W-1:0]   r_sum;
    logic [NUM_W-1:0]   r_num;
    logic [PROD_W-1:0]  r_prod;
    t_tag               r_tag2, r_tag3, r_tag4;
    logic [Q_W-1:0]     quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= i_sum;
        r_tag2 <= i_tag;
        r_num  <= NUM_W'(r_sum) * NUM_W'(SCALE) + BIAS;
        r_tag3 <= r_tag2;
        r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
        r_tag4 <= r_tag3;
    end

    assign quo       = r_prod[PROD_W-1:SHIFT];
    assign o_level   = (quo > Q_W'(LEVEL_MAX)) ? LEVEL_MAX : quo[LEVEL_W-1:0];
    assign o_valid   = r_v4;
    assign o_tag     = r_tag4;
    assign o_pending = 2'(r_v2) + 2'(r_v3) + 2'(r_v4);

endmodule

// File: rtl/core/bap_sva.sv
// ----------------------------------------------------------------------------
// bap_sva
// Port-level checks of the block average pooling core, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bap_sva import bap_pkg::*; #(
    parameter int IMAGE_SIDE = IMAGE_SIDE_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    localparam int BPR   = IMAGE_SIDE / BLOCK_SIZE;
    localparam int PAD_W = OUT_DATA_W - BIN_W - LEVEL_W;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BPR * BPR - 1);

    logic [BIN_W-1:0]    bin;
    logic [LEVEL_W-1:0]  level;
    logic [PAD_W-1:0]    pad;
    logic [OUT_DATA_W:0] beat;      // tlast above tdata
    logic                stall;
    logic                last_beat;

    assign bin       = o_m_axis_tdata[BIN_W-1:0];
    assign level     = o_m_axis_tdata[BIN_W +: LEVEL_W];
    assign pad       = o_m_axis_tdata[OUT_DATA_W-1:BIN_W+LEVEL_W];
    assign beat      = {o_m_axis_tlast, o_m_axis_tdata};
    assign stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign last_beat = o_m_axis_tvalid && o_m_axis_tlast;

    `BAP_ASSERT(a_out_hold, stall |=> o_m_axis_tvalid && $stable(beat), "result changed in stall")

    `BAP_ASSERT(a_level_range, o_m_axis_tvalid |-> level <= LEVEL_MAX && pad == '0, "bad level")

    `BAP_ASSERT(a_last_bin, last_beat |-> bin == LAST_BIN, "tlast off the final block")

    `BAP_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_m_axis_tvalid, "result present after reset")

endmodule

bind block_average_pooling_top bap_sva #(
    .IMAGE_SIDE (IMAGE_SIDE),
    .BLOCK_SIZE (BLOCK_SIZE)
) u_bap_sva (.*);
